FILE: rtl/bgsm_pkg.sv
package bgsm_pkg;

  // buffer geometry
  localparam int BUFFER_BYTES = 4096;
  localparam int ROW_BYTES    = 8;
  localparam int ROWS         = (BUFFER_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int BANK_ROWS    = (ROWS + 1) / 2;
  localparam int ROW_AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BANK_AW      = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

  // field widths
  localparam int OFF_W   = 15;
  localparam int LEN_W   = 7;
  localparam int VAL_W   = 64;
  localparam int POS_W   = 6;
  localparam int BYTE_AW = OFF_W - 3;
  localparam int END_W   = 17;
  localparam int ROW_W   = 64;
  localparam int WIN_W   = 128;
  localparam int SH_W    = 7;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    WS_8,
    WS_16,
    WS_32,
    WS_64
  } wsize_t;

  // decoded access, held for the life of one item
  typedef struct packed {
    logic              cmd;
    wsize_t            wsz;
    logic [POS_W-1:0]  s;
    logic [LEN_W-1:0]  len;
    logic [2:0]        byte_ofs;
    logic [ROW_AW-1:0] row;
    logic              span;
    logic              big;
    logic              err;
  } item_t;

endpackage

FILE: rtl/bgsm_if.sv
interface bgsm_req_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [bgsm_pkg::OFF_W-1:0]   bit_offset;
  logic [bgsm_pkg::LEN_W-1:0]   field_length;
  logic                         network_order;
  logic [bgsm_pkg::VAL_W-1:0]   write_value;

  modport source (
    output valid, command, bit_offset, field_length, network_order, write_value,
    input  ready
  );
  modport sink (
    input  valid, command, bit_offset, field_length, network_order, write_value,
    output ready
  );
endinterface

interface bgsm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bgsm_pkg::VAL_W-1:0]   read_data;
  logic                         range_error;

  modport source (
    output valid, read_data, range_error,
    input  ready
  );
  modport sink (
    input  valid, read_data, range_error,
    output ready
  );
endinterface

FILE: rtl/bitfield_get_set_memory_core.sv
// Steps: accept in ST_IDLE (rows read), window load in ST_LOAD, then
//   modify/write in ST_FINISH; no new request is taken before it ends;
//   rows A and A+1 sit in opposite banks, so one read and one write cover
//   both words of a spanning field. A held result stalls only the final step.
// Reset: synchronous; afterwards a clearing pass over all BANK_ROWS rows
//   of each bank (256 at 4096 bytes) zeroes both banks with req.ready low.
module bitfield_get_set_memory_core (
  input  logic         clk,
  input  logic         rst,
  bgsm_req_if.sink     req,
  bgsm_rsp_if.source   rsp
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_FINISH
  } state_t;

  // Store: 8-byte rows, little-endian bytes, even and odd rows in separate
  // banks so that rows A and A+1 are reached in the same cycle.
  logic [bgsm_pkg::ROW_W-1:0] bank_even [bgsm_pkg::BANK_ROWS];
  logic [bgsm_pkg::ROW_W-1:0] bank_odd  [bgsm_pkg::BANK_ROWS];
  logic [bgsm_pkg::ROW_W-1:0] rd_even;
  logic [bgsm_pkg::ROW_W-1:0] rd_odd;

  state_t                        state;
  logic [bgsm_pkg::BANK_AW-1:0]  clr_idx;
  bgsm_pkg::item_t               item;
  logic [bgsm_pkg::VAL_W-1:0]    val;
  logic [bgsm_pkg::WIN_W-1:0]    y;
  logic [bgsm_pkg::WIN_W-1:0]    rows;
  logic [bgsm_pkg::WIN_W-1:0]    fmask;
  logic [bgsm_pkg::WIN_W-1:0]    vsh;
  logic                          rsp_valid;
  logic [bgsm_pkg::VAL_W-1:0]    rsp_data;
  logic                          rsp_err;

  // ---- request decode (accept cycle) ----
  bgsm_pkg::item_t               dec;
  logic [bgsm_pkg::BYTE_AW-1:0]  addr;
  logic [3:0]                    nb;
  logic [7:0]                    wbits;
  logic [7:0]                    s_plus_len;
  logic [bgsm_pkg::END_W-1:0]    end_b;
  logic                          bad_len;
  logic                          accept;

  assign accept = req.valid && req.ready;

  always_comb begin
    bad_len = (req.field_length == '0) ||
              (req.field_length > bgsm_pkg::LEN_W'(64));
    // smallest word that holds the field
    priority if (req.field_length <= bgsm_pkg::LEN_W'(8)) begin
      dec.wsz = bgsm_pkg::WS_8;
    end else if (req.field_length <= bgsm_pkg::LEN_W'(16)) begin
      dec.wsz = bgsm_pkg::WS_16;
    end else if (req.field_length <= bgsm_pkg::LEN_W'(32)) begin
      dec.wsz = bgsm_pkg::WS_32;
    end else begin
      dec.wsz = bgsm_pkg::WS_64;
    end
    // bit within word, and byte address of the (aligned) word
    unique case (dec.wsz)
      bgsm_pkg::WS_8: begin
        dec.s = {3'b0, req.bit_offset[2:0]};
        addr  = req.bit_offset[bgsm_pkg::OFF_W-1:3];
        nb    = 4'd1;
        wbits = 8'd8;
      end
      bgsm_pkg::WS_16: begin
        dec.s = {2'b0, req.bit_offset[3:0]};
        addr  = {req.bit_offset[bgsm_pkg::OFF_W-1:4], 1'b0};
        nb    = 4'd2;
        wbits = 8'd16;
      end
      bgsm_pkg::WS_32: begin
        dec.s = {1'b0, req.bit_offset[4:0]};
        addr  = {req.bit_offset[bgsm_pkg::OFF_W-1:5], 2'b0};
        nb    = 4'd4;
        wbits = 8'd32;
      end
      bgsm_pkg::WS_64: begin
        dec.s = req.bit_offset[5:0];
        addr  = {req.bit_offset[bgsm_pkg::OFF_W-1:6], 3'b0};
        nb    = 4'd8;
        wbits = 8'd64;
      end
    endcase
    s_plus_len   = {2'b0, dec.s} + {1'b0, req.field_length};
    dec.span     = s_plus_len > wbits;
    end_b        = bgsm_pkg::END_W'(addr) + bgsm_pkg::END_W'(nb) +
                   (dec.span ? bgsm_pkg::END_W'(nb) : bgsm_pkg::END_W'(0));
    dec.err      = bad_len || (end_b > bgsm_pkg::END_W'(bgsm_pkg::BUFFER_BYTES));
    dec.cmd      = req.command;
    dec.len      = req.field_length;
    dec.byte_ofs = addr[2:0];
    dec.row      = bgsm_pkg::ROW_AW'(addr[bgsm_pkg::BYTE_AW-1:3]);
    dec.big      = req.network_order &&
                   (dec.wsz == bgsm_pkg::WS_16 || dec.wsz == bgsm_pkg::WS_32);
  end

  // Bank index of rows A and A+1: the odd bank always reads A>>1;
  // the even bank holds (A+1)>>1.
  logic [bgsm_pkg::ROW_AW:0]     dec_row_p1;
  logic [bgsm_pkg::ROW_AW:0]     item_row_p1;
  logic [bgsm_pkg::BANK_AW-1:0]  ra_even;
  logic [bgsm_pkg::BANK_AW-1:0]  ra_odd;

  assign dec_row_p1  = {1'b0, dec.row} + (bgsm_pkg::ROW_AW + 1)'(1);
  assign item_row_p1 = {1'b0, item.row} + (bgsm_pkg::ROW_AW + 1)'(1);
  assign ra_even     = bgsm_pkg::BANK_AW'(dec_row_p1 >> 1);
  assign ra_odd      = bgsm_pkg::BANK_AW'(dec.row >> 1);

  // ---- window pack / unpack ----
  logic [bgsm_pkg::WIN_W-1:0] rows_cur;
  logic [bgsm_pkg::WIN_W-1:0] y_cur;
  logic [bgsm_pkg::WIN_W-1:0] y_new;
  logic [bgsm_pkg::WIN_W-1:0] rows_new;

  bgsm_window u_window (
    .ctl       (item),
    .rd_even   (rd_even),
    .rd_odd    (rd_odd),
    .rows_held (rows),
    .y_new     (y_new),
    .rows_cur  (rows_cur),
    .y_cur     (y_cur),
    .rows_new  (rows_new)
  );

  // Field position in the window: shift from the window LSB to the field LSB.
  logic [7:0]                  sh_full;
  logic [bgsm_pkg::SH_W-1:0]   sh;
  logic [bgsm_pkg::VAL_W-1:0]  lowmask;
  logic [bgsm_pkg::WIN_W-1:0]  field_bits;
  logic [bgsm_pkg::VAL_W-1:0]  rd_field;

  assign sh_full    = 8'd128 - ({2'b0, item.s} + {1'b0, item.len});
  assign sh         = sh_full[bgsm_pkg::SH_W-1:0];
  assign lowmask    = ~({bgsm_pkg::VAL_W{1'b1}} << item.len);
  assign y_new      = (y & ~fmask) | vsh;
  assign field_bits = (y & fmask) >> sh;
  assign rd_field   = field_bits[bgsm_pkg::VAL_W-1:0];

  // ---- finish step and write-back ----
  logic                          fin;
  logic                          wr;
  logic                          clearing;
  logic                          we_even;
  logic                          we_odd;
  logic [bgsm_pkg::BANK_AW-1:0]  wa_even;
  logic [bgsm_pkg::BANK_AW-1:0]  wa_odd;
  logic [bgsm_pkg::ROW_W-1:0]    wd_even;
  logic [bgsm_pkg::ROW_W-1:0]    wd_odd;

  assign fin      = (state == ST_FINISH) && (!rsp_valid || rsp.ready);
  assign wr       = fin && !item.err && (item.cmd == bgsm_pkg::CMD_WRITE);
  assign clearing = (state == ST_CLEAR);

  // clear zeroes both banks; writes rewrite row A, row A+1 only on a span
  always_comb begin
    if (clearing) begin
      we_even = 1'b1;
      we_odd  = 1'b1;
      wa_even = clr_idx;
      wa_odd  = clr_idx;
      wd_even = '0;
      wd_odd  = '0;
    end else begin
      we_even = wr && (!item.row[0] || item.span);
      we_odd  = wr && (item.row[0] || item.span);
      wa_even = bgsm_pkg::BANK_AW'(item_row_p1 >> 1);
      wa_odd  = bgsm_pkg::BANK_AW'(item.row >> 1);
      wd_even = item.row[0] ? rows_new[127:64] : rows_new[63:0];
      wd_odd  = item.row[0] ? rows_new[63:0]   : rows_new[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (we_even) begin
      bank_even[wa_even] <= wd_even;
    end
    if (we_odd) begin
      bank_odd[wa_odd] <= wd_odd;
    end
    rd_even <= bank_even[ra_even];
    rd_odd  <= bank_odd[ra_odd];
  end

  // ---- sequencer, item registers and result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // result register: loaded at the end of an item, freed when taken
      if (fin) begin
        rsp_valid <= 1'b1;
        rsp_err   <= item.err;
        rsp_data  <= (item.err || item.cmd == bgsm_pkg::CMD_WRITE) ? '0 : rd_field;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_idx == bgsm_pkg::BANK_AW'(bgsm_pkg::BANK_ROWS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_idx <= clr_idx + bgsm_pkg::BANK_AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item  <= dec;
            val   <= req.write_value;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // memory data for rows A and A+1 is valid this cycle
          y     <= y_cur;
          rows  <= rows_cur;
          fmask <= bgsm_pkg::WIN_W'(lowmask) << sh;
          vsh   <= bgsm_pkg::WIN_W'(val & lowmask) << sh;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.read_data   = rsp_data;
  assign rsp.range_error = rsp_err;

`ifndef SYNTH
  a_wr_phase: assert property (@(posedge clk) disable iff (rst)
    (we_even || we_odd) |-> (state == ST_CLEAR || state == ST_FINISH))
    else $error("store written outside clear or finish");

  a_read_no_wr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && item.cmd == bgsm_pkg::CMD_READ) |-> !(we_even || we_odd))
    else $error("read access wrote the store");

  a_err_no_wr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && item.err) |-> !(we_even || we_odd))
    else $error("refused access wrote the store");

  a_both_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && we_even && we_odd) |-> item.span)
    else $error("second row written for a field that does not span");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_err) |-> (rsp_data == '0))
    else $error("range error beat carries data");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOAD))
    else $error("accepted beat did not start a load");
`endif

endmodule

FILE: rtl/bgsm_window.sv
// Row pair <-> field window. The window holds the first word then the
// second word, MSB-justified, each in value order (swapped if big).
module bgsm_window (
  input  bgsm_pkg::item_t               ctl,
  input  logic [bgsm_pkg::ROW_W-1:0]    rd_even,
  input  logic [bgsm_pkg::ROW_W-1:0]    rd_odd,
  input  logic [bgsm_pkg::WIN_W-1:0]    rows_held,
  input  logic [bgsm_pkg::WIN_W-1:0]    y_new,
  output logic [bgsm_pkg::WIN_W-1:0]    rows_cur,
  output logic [bgsm_pkg::WIN_W-1:0]    y_cur,
  output logic [bgsm_pkg::WIN_W-1:0]    rows_new
);

  function automatic logic [15:0] ord16(input logic [15:0] x, input logic big);
    return big ? {x[7:0], x[15:8]} : x;
  endfunction

  function automatic logic [31:0] ord32(input logic [31:0] x, input logic big);
    return big ? {x[7:0], x[15:8], x[23:16], x[31:24]} : x;
  endfunction

  logic [5:0]                   bsh;
  logic [bgsm_pkg::WIN_W-1:0]   shifted;
  logic [bgsm_pkg::WIN_W-1:0]   z;
  logic [bgsm_pkg::WIN_W-1:0]   zm;

  assign bsh = {ctl.byte_ofs, 3'b000};

  // row A in the low half, little-endian bytes
  always_comb begin
    rows_cur = ctl.row[0] ? {rd_even, rd_odd} : {rd_odd, rd_even};
    shifted  = rows_cur >> bsh;
    unique case (ctl.wsz)
      bgsm_pkg::WS_8:  y_cur = {shifted[7:0], shifted[15:8], 112'b0};
      bgsm_pkg::WS_16: y_cur = {ord16(shifted[15:0], ctl.big),
                                ord16(shifted[31:16], ctl.big), 96'b0};
      bgsm_pkg::WS_32: y_cur = {ord32(shifted[31:0], ctl.big),
                                ord32(shifted[63:32], ctl.big), 64'b0};
      bgsm_pkg::WS_64: y_cur = {shifted[63:0], shifted[127:64]};
    endcase
  end

  always_comb begin
    unique case (ctl.wsz)
      bgsm_pkg::WS_8: begin
        z  = {112'b0, y_new[119:112], y_new[127:120]};
        zm = {112'b0, {16{1'b1}}};
      end
      bgsm_pkg::WS_16: begin
        z  = {96'b0, ord16(y_new[111:96], ctl.big), ord16(y_new[127:112], ctl.big)};
        zm = {96'b0, {32{1'b1}}};
      end
      bgsm_pkg::WS_32: begin
        z  = {64'b0, ord32(y_new[95:64], ctl.big), ord32(y_new[127:96], ctl.big)};
        zm = {64'b0, {64{1'b1}}};
      end
      bgsm_pkg::WS_64: begin
        z  = {y_new[63:0], y_new[127:64]};
        zm = {bgsm_pkg::WIN_W{1'b1}};
      end
    endcase
    rows_new = (rows_held & ~(zm << bsh)) | (z << bsh);
  end

endmodule
